### hw/rtl/afg_pkg.sv
// Shared types and constants for the LED frame generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package afg_pkg;

  localparam int unsigned MAX_LEDS    = 512;
  localparam int unsigned COUNT_W     = 10;
  localparam int unsigned BRIGHT_W    = 5;
  localparam int unsigned CFG_DATA_W  = 10;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned ENDS_W      = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd1;

  localparam logic [COUNT_W-1:0]  LED_COUNT_RST  = 10'd1;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RST = 5'd31;
  localparam logic [COUNT_W-1:0]  COUNT_MAX      = 10'(MAX_LEDS);
  localparam logic [7:0]          HDR_BASE       = 8'hE0;
  localparam logic [7:0]          ZERO_BYTE      = 8'h00;
  // last index of a four-byte start or reset run
  localparam logic [ENDS_W-1:0]   PAD_LAST       = 5'd3;

  typedef struct packed {
    logic [7:0] color_first;
    logic [7:0] color_second;
    logic [7:0] color_third;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } res_t;

  // one classified pixel, handed from front to back
  typedef struct packed {
    logic              start;    // first pixel of the frame
    logic              last;     // last pixel of the frame
    logic [7:0]        hdr;      // header byte
    logic [ENDS_W-1:0] ends_m1;  // end bytes minus one
    pix_t              pix;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_BEGIN,
    ST_START,
    ST_HDR,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_RST,
    ST_END
  } st_t;

endpackage
`default_nettype wire

### hw/rtl/afg_front.sv
// Front end: config registers, pixel counter and per-pixel classification.
// Depends on afg_pkg.
`default_nettype none
module afg_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [afg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [afg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire afg_pkg::pix_t                in_data,
  input  wire logic                         q_full,
  output logic                              q_push,
  output afg_pkg::cmd_t                     q_cmd
);
  import afg_pkg::*;

  logic [COUNT_W-1:0]  led_count_r;
  logic [BRIGHT_W-1:0] brightness_r;
  logic [COUNT_W-1:0]  pixel_index_r;
  logic [COUNT_W-1:0]  pixel_index_nxt;
  logic [COUNT_W-1:0]  count_eff;
  logic [COUNT_W-1:0]  ends_m1_w;
  logic                last_pix;

  always_comb begin
    if (led_count_r == '0) begin
      count_eff = COUNT_W'(1);
    end else if (led_count_r > COUNT_MAX) begin
      count_eff = COUNT_MAX;
    end else begin
      count_eff = led_count_r;
    end
  end

  // ceil(count/16) - 1
  assign ends_m1_w       = ((count_eff + COUNT_W'(15)) >> 4) - COUNT_W'(1);
  assign pixel_index_nxt = pixel_index_r + COUNT_W'(1);
  assign last_pix        = (pixel_index_nxt >= count_eff);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.start   = (pixel_index_r == '0);
    q_cmd.last    = last_pix;
    q_cmd.hdr     = HDR_BASE | {3'b000, brightness_r};
    q_cmd.ends_m1 = ends_m1_w[ENDS_W-1:0];
    q_cmd.pix     = in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r   <= LED_COUNT_RST;
      brightness_r  <= BRIGHTNESS_RST;
      pixel_index_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_LED_COUNT:  led_count_r  <= cfg_wdata[COUNT_W-1:0];
          REG_BRIGHTNESS: brightness_r <= cfg_wdata[BRIGHT_W-1:0];
          default: ;
        endcase
      end
      if (q_push) begin
        pixel_index_r <= last_pix ? '0 : pixel_index_nxt;
      end
    end
  end

  // index returns to zero after the last pixel of a frame
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(q_push) && $past(q_cmd.last) |-> pixel_index_r == '0)
    else $error("pixel index not rearmed after last pixel");

  a_start_idx: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_cmd.start |-> pixel_index_r == '0)
    else $error("start flag without frame start");

  a_ends_rng: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ends_m1_w < COUNT_W'(32))
    else $error("end byte count out of range");

endmodule
`default_nettype wire

### hw/rtl/afg_queue.sv
// Two-entry queue of classified pixels between front and back.
// Depends on afg_pkg.
`default_nettype none
module afg_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire afg_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output afg_pkg::cmd_t      head_cmd
);
  import afg_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;

  assign full       = (fill_r == 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue overflow");

  a_no_udf: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !head_valid))
    else $error("queue underflow");

  a_ptr_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == 2'd0) || (fill_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

### hw/rtl/afg_back.sv
// Back end: byte sequencer that expands one queued pixel into frame bytes,
// with a registered output stage. Depends on afg_pkg.
`default_nettype none
module afg_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire afg_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output afg_pkg::res_t      out_data
);
  import afg_pkg::*;

  st_t               st_r, st_nxt;
  logic [ENDS_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r;
  res_t              out_data_r;
  res_t              res;
  logic              fire;

  assign fire      = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    pop     = 1'b0;
    if (fire) begin
      unique case (st_r)
        ST_BEGIN: begin
          if (head_cmd.start) begin
            st_nxt  = ST_START;
            cnt_nxt = ENDS_W'(1);
          end else begin
            st_nxt = ST_C1;
          end
        end
        ST_START: begin
          if (cnt_r == PAD_LAST) begin
            st_nxt  = ST_HDR;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + ENDS_W'(1);
          end
        end
        ST_HDR: st_nxt = ST_C1;
        ST_C1:  st_nxt = ST_C2;
        ST_C2:  st_nxt = ST_C3;
        ST_C3: begin
          if (head_cmd.last) begin
            st_nxt  = ST_RST;
            cnt_nxt = '0;
          end else begin
            st_nxt = ST_BEGIN;
            pop    = 1'b1;
          end
        end
        ST_RST: begin
          if (cnt_r == PAD_LAST) begin
            st_nxt  = ST_END;
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + ENDS_W'(1);
          end
        end
        ST_END: begin
          if (cnt_r == head_cmd.ends_m1) begin
            st_nxt  = ST_BEGIN;
            cnt_nxt = '0;
            pop     = 1'b1;
          end else begin
            cnt_nxt = cnt_r + ENDS_W'(1);
          end
        end
        default: st_nxt = ST_BEGIN;
      endcase
    end
  end

  // byte for the current step
  always_comb begin
    res.out_byte   = ZERO_BYTE;
    res.run_last   = 1'b0;
    res.frame_done = 1'b0;
    unique case (st_r)
      ST_BEGIN: res.out_byte = head_cmd.start ? ZERO_BYTE : head_cmd.hdr;
      ST_START: res.out_byte = ZERO_BYTE;
      ST_HDR:   res.out_byte = head_cmd.hdr;
      ST_C1:    res.out_byte = head_cmd.pix.color_first;
      ST_C2:    res.out_byte = head_cmd.pix.color_second;
      ST_C3: begin
        res.out_byte = head_cmd.pix.color_third;
        res.run_last = !head_cmd.last;
      end
      ST_RST:   res.out_byte = ZERO_BYTE;
      ST_END: begin
        res.run_last   = (cnt_r == head_cmd.ends_m1);
        res.frame_done = (cnt_r == head_cmd.ends_m1);
      end
      default: res.out_byte = ZERO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_BEGIN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_done |-> out_data_r.run_last)
    else $error("frame_done without run_last");

  a_pop_state: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (st_r == ST_C3) || (st_r == ST_END))
    else $error("pixel retired mid-sequence");

  a_pop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> res.run_last)
    else $error("pixel retired without run_last byte");

endmodule
`default_nettype wire

### hw/rtl/apa102_frame_generator_core.sv
// Top level of the LED frame generator: front end, pixel queue, back end.
// Depends on afg_pkg, afg_front, afg_queue, afg_back.
`default_nettype none
// Usage
//   Input channel (in_valid/in_ready/in_data): one pixel per transaction,
//   three color bytes in the order they go on the wire.
//   Output channel (out_valid/out_ready/out_data): one frame byte per
//   transaction, MSB first on the LED data line; run_last marks the last
//   byte a pixel causes, frame_done the last end byte of a frame.
//   Config port (cfg_we/cfg_idx/cfg_wdata): index 0 LED count, 1 brightness.
//   Write only while idle.
// Timing
//   An accepted pixel enters the queue; at the head, with the output free,
//   its first byte is registered into out_data. The back end emits one byte
//   per cycle while a pixel is queued and output is not stalled: 4 bytes for
//   a plain pixel, 4 more for frame start, 4+ceil(count/16) for frame tail.
//   The two-entry queue lets a new pixel in while the back end still works,
//   so input throughput is set by the back end's byte rate.
// Reset
//   Synchronous, active low: LED count 1, brightness 31, frame start, queue
//   and output empty.
// Stall
//   A stalled output holds its byte; the back end waits, the queue fills
//   and in_ready drops once both entries are taken.
module apa102_frame_generator_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [afg_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [afg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire afg_pkg::pix_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output afg_pkg::res_t                       out_data
);
  import afg_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  // classify pixels and track frame position
  afg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  // decouples acceptance from byte generation
  afg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wr_cmd     (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // byte sequencer and output register
  afg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire
